FILE: rtl/core/gnt_pkg.sv
// Package for the geographic neighbor table: mode, status, angle class and FSM codes.
// No dependencies; imported by every module of the block.
`default_nettype none

package gnt_pkg;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_DEL    = 3'd1;
    localparam logic [2:0] MODE_CLEAR  = 3'd2;
    localparam logic [2:0] MODE_QUERY  = 3'd3;
    localparam logic [2:0] MODE_LOOKUP = 3'd4;
    localparam logic [2:0] MODE_GREEDY = 3'd5;
    localparam logic [2:0] MODE_PERIM  = 3'd6;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_NONE = 2'd2;

    // angle classes against the reference edge, ordered by rank
    localparam logic [2:0] H_LEFT  = 3'd0;  // (0,180)
    localparam logic [2:0] H_BACK  = 3'd1;  // exactly 180
    localparam logic [2:0] H_RIGHT = 3'd2;  // (180,360)
    localparam logic [2:0] H_SAME  = 3'd3;  // same direction, ranked as 360
    localparam logic [2:0] H_NONE  = 3'd4;  // no candidate yet

    localparam logic [31:0]        LIFETIME_RESET = 32'd3000;
    localparam logic signed [31:0] INV_OUT        = -32'sd256;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_HEAD  = 7'b0000100,
        ST_START = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_EVAL  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/gnt_cell.sv
// One table cell of the rotating entry chain: valid, address, position, stamp.
// Uses gnt_pkg; instantiated by geographic_neighbor_table.
`default_nettype none

module gnt_cell
    import gnt_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int TIME_BITS  = 32
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           shift,
    input  wire                           in_valid,
    input  wire        [31:0]             in_addr,
    input  wire signed [COORD_BITS-1:0]   in_x,
    input  wire signed [COORD_BITS-1:0]   in_y,
    input  wire        [TIME_BITS-1:0]    in_stamp,
    output logic                          out_valid,
    output logic       [31:0]             out_addr,
    output logic signed [COORD_BITS-1:0]  out_x,
    output logic signed [COORD_BITS-1:0]  out_y,
    output logic       [TIME_BITS-1:0]    out_stamp
);

    logic                         valid_reg, valid_next;
    logic        [31:0]           addr_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic        [TIME_BITS-1:0]  stamp_reg;

    assign valid_next = shift ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            addr_reg  <= in_addr;
            x_reg     <= in_x;
            y_reg     <= in_y;
            stamp_reg <= in_stamp;
        end
    end

    assign out_valid = valid_reg;
    assign out_addr  = addr_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_stamp = stamp_reg;

endmodule

`default_nettype wire

FILE: rtl/core/gnt_mul.sv
// Sequential signed multiplier: four half-width partial products, one per cycle.
// Uses gnt_pkg; instantiated by geographic_neighbor_table.
`default_nettype none

module gnt_mul
    import gnt_pkg::*;
#(
    parameter int W = 33
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    input  wire signed [W-1:0]     a,
    input  wire signed [W-1:0]     b,
    output logic                   done,
    output logic signed [2*W-1:0]  p
);

    localparam int H   = (W + 1) / 2;
    localparam int HW2 = 2 * H;
    localparam int AW  = 4 * H;
    localparam int PW  = 2 * W;

    logic              run_reg, run_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [HW2-1:0]    ma_reg, ma_next, mb_reg, mb_next;
    logic              neg_reg, neg_next;
    logic [HW2-1:0]    pp_reg, pp_next;
    logic [1:0]        sh_reg, sh_next;
    logic [AW-1:0]     acc_reg, acc_next;
    logic signed [PW-1:0] p_reg, p_next;

    logic [W-1:0]      a_mag, b_mag;
    logic [H-1:0]      op_x, op_y;
    logic [AW-1:0]     pp_ext, pp_sh;

    assign a_mag = a[W-1] ? (~a + 1'b1) : a;
    assign b_mag = b[W-1] ? (~b + 1'b1) : b;
    assign pp_ext = AW'(pp_reg);

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext << H;
            default: pp_sh = pp_ext << HW2;
        endcase
        case (cnt_reg[1:0])
            2'd0:
            begin
                op_x = ma_reg[H-1:0];
                op_y = mb_reg[H-1:0];
            end
            2'd1:
            begin
                op_x = ma_reg[H-1:0];
                op_y = mb_reg[HW2-1:H];
            end
            2'd2:
            begin
                op_x = ma_reg[HW2-1:H];
                op_y = mb_reg[H-1:0];
            end
            default:
            begin
                op_x = ma_reg[HW2-1:H];
                op_y = mb_reg[HW2-1:H];
            end
        endcase
    end

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        p_next    = p_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 3'd0;
            ma_next  = HW2'(a_mag);
            mb_next  = HW2'(b_mag);
            neg_next = a[W-1] ^ b[W-1];
            acc_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg < 3'd4)
            begin
                pp_next = HW2'(op_x) * HW2'(op_y);
                case (cnt_reg[1:0])
                    2'd0:    sh_next = 2'd0;
                    2'd3:    sh_next = 2'd2;
                    default: sh_next = 2'd1;
                endcase
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                acc_next = acc_reg + pp_sh;
            end
            if (cnt_reg == 3'd5)
            begin
                p_next    = $signed(PW'(neg_reg ? (~acc_reg + 1'b1) : acc_reg));
                done_next = 1'b1;
                run_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        p_reg   <= p_next;
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

`default_nettype wire

FILE: rtl/core/geographic_neighbor_table.sv
// Top level of the geographic neighbor table: APB register, item sequencer, cell chain.
// Depends on gnt_pkg, gnt_cell and gnt_mul.
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+-------------------------------------------
//  item in   | start & !busy at rising edge      | mode, now, node_addr, pos/self/prev x,y
//  result    | done, one cycle, no backpressure  | chosen_addr, found, found_x/y, stamp, status
//  config    | psel & penable & pwrite (pready=1)| paddr 0: entry_lifetime
//
// Every item rotates the whole chain once: the entry at cell 0 is examined, possibly
// rewritten (add, delete, clear, purge) and moved to the last cell. Greedy also squares
// the distance of each live entry plus one self distance; perimeter works cross and, where
// needed, dot and tie-break products for each eligible entry. All products go through the
// shared multiplier (4 partial products), one product at a time.
// Reset clears all valid bits and sets entry_lifetime to 3000; busy is low after reset.
// Results cannot be stalled: done pulses in the cycle busy drops, and a new item may be
// started in that same cycle.
`default_nettype none

module geographic_neighbor_table
    import gnt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int COORD_BITS    = 32,
    parameter int TIME_BITS     = 32
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire        [2:0]   paddr,
    input  wire        [31:0]  pwdata,
    output logic       [31:0]  prdata,
    output logic               pready,
    input  wire                start,
    output logic               busy,
    input  wire        [2:0]   mode,
    input  wire        [31:0]  now,
    input  wire        [31:0]  node_addr,
    input  wire signed [31:0]  pos_x,
    input  wire signed [31:0]  pos_y,
    input  wire signed [31:0]  self_x,
    input  wire signed [31:0]  self_y,
    input  wire signed [31:0]  prev_x,
    input  wire signed [31:0]  prev_y,
    output logic               done,
    output logic       [31:0]  chosen_addr,
    output logic               found,
    output logic signed [31:0] found_x,
    output logic signed [31:0] found_y,
    output logic       [31:0]  found_stamp,
    output logic       [1:0]   status
);

    localparam int W    = COORD_BITS + 1;     // coordinate difference
    localparam int PW   = 2 * W;              // product
    localparam int CW   = PW + 1;             // sum or difference of two products
    localparam int LW   = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int CNTW = $clog2(TABLE_ENTRIES);
    localparam logic signed [COORD_BITS-1:0] INV_C = COORD_BITS'(-256);

    // ---------------- configuration register ----------------
    logic [31:0] life_reg, life_next;

    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? 32'd0 : life_reg;
    assign life_next = (psel && penable && pwrite && !paddr[2]) ? pwdata : life_reg;

    // ---------------- cell chain ----------------
    logic                         c_valid [TABLE_ENTRIES];
    logic        [31:0]           c_addr  [TABLE_ENTRIES];
    logic signed [COORD_BITS-1:0] c_x     [TABLE_ENTRIES];
    logic signed [COORD_BITS-1:0] c_y     [TABLE_ENTRIES];
    logic        [TIME_BITS-1:0]  c_stamp [TABLE_ENTRIES];

    logic                         shift;
    logic                         wb_valid;
    logic        [31:0]           wb_addr;
    logic signed [COORD_BITS-1:0] wb_x, wb_y;
    logic        [TIME_BITS-1:0]  wb_stamp;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            if (gi == TABLE_ENTRIES - 1)
            begin : g_tail
                gnt_cell #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .in_valid(wb_valid), .in_addr(wb_addr), .in_x(wb_x), .in_y(wb_y),
                    .in_stamp(wb_stamp),
                    .out_valid(c_valid[gi]), .out_addr(c_addr[gi]), .out_x(c_x[gi]),
                    .out_y(c_y[gi]), .out_stamp(c_stamp[gi])
                );
            end
            else
            begin : g_body
                gnt_cell #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .in_valid(c_valid[gi+1]), .in_addr(c_addr[gi+1]), .in_x(c_x[gi+1]),
                    .in_y(c_y[gi+1]), .in_stamp(c_stamp[gi+1]),
                    .out_valid(c_valid[gi]), .out_addr(c_addr[gi]), .out_x(c_x[gi]),
                    .out_y(c_y[gi]), .out_stamp(c_stamp[gi])
                );
            end
        end
    endgenerate

    // head of the chain
    logic                         h_valid;
    logic        [31:0]           h_addr;
    logic signed [COORD_BITS-1:0] h_x, h_y;
    logic        [TIME_BITS-1:0]  h_stamp;

    assign h_valid = c_valid[0];
    assign h_addr  = c_addr[0];
    assign h_x     = c_x[0];
    assign h_y     = c_y[0];
    assign h_stamp = c_stamp[0];

    // ---------------- sequencer state ----------------
    state_t                       state_reg, state_next;
    logic [CNTW-1:0]              cnt_reg, cnt_next;
    logic [2:0]                   k_reg, k_next;
    logic                         self_phase_reg, self_phase_next;
    logic                         written_reg, written_next;
    logic                         have_best_reg, have_best_next;
    logic [2:0]                   bh_reg, bh_next;
    logic                         q_found_reg, q_found_next;
    logic                         done_reg, done_next;

    logic [2:0]                   mode_reg, mode_next;
    logic [TIME_BITS-1:0]         now_reg, now_next;
    logic [31:0]                  addr_reg, addr_next;
    logic signed [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [COORD_BITS-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [COORD_BITS-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [W-1:0]          rx_reg, rx_next, ry_reg, ry_next;
    logic signed [W-1:0]          cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [W-1:0]          bx_reg, bx_next, by_reg, by_next;
    logic signed [PW-1:0]         pa_reg, pa_next;
    logic signed [CW-1:0]         comb_reg, comb_next;
    logic signed [CW-1:0]         self_d_reg, self_d_next;
    logic signed [CW-1:0]         best_d_reg, best_d_next;
    logic [31:0]                  best_addr_reg, best_addr_next;
    logic signed [COORD_BITS-1:0] q_x_reg, q_x_next, q_y_reg, q_y_next;
    logic [TIME_BITS-1:0]         q_stamp_reg, q_stamp_next;

    logic [31:0]                  o_addr_reg, o_addr_next;
    logic                         o_found_reg, o_found_next;
    logic signed [31:0]           o_x_reg, o_x_next, o_y_reg, o_y_next;
    logic [31:0]                  o_stamp_reg, o_stamp_next;
    logic [1:0]                   o_status_reg, o_status_next;

    // ---------------- multiplier ----------------
    logic                 mul_start, mul_done;
    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    gnt_mul #(.W(W)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .p(mul_p)
    );

    assign mul_start = (state_reg == ST_START);

    // operand schedule: greedy squares dx, dy; perimeter works cross(r,n), dot(r,n),
    // then cross(n,best) for a tie in class
    always_comb
    begin
        if (mode_reg == MODE_GREEDY)
        begin
            mul_a = k_reg[0] ? cur_y_reg : cur_x_reg;
            mul_b = mul_a;
        end
        else
        begin
            case (k_reg)
                3'd0:
                begin
                    mul_a = rx_reg;
                    mul_b = cur_y_reg;
                end
                3'd1:
                begin
                    mul_a = ry_reg;
                    mul_b = cur_x_reg;
                end
                3'd2:
                begin
                    mul_a = rx_reg;
                    mul_b = cur_x_reg;
                end
                3'd3:
                begin
                    mul_a = ry_reg;
                    mul_b = cur_y_reg;
                end
                3'd4:
                begin
                    mul_a = cur_x_reg;
                    mul_b = by_reg;
                end
                default:
                begin
                    mul_a = cur_y_reg;
                    mul_b = bx_reg;
                end
            endcase
        end
    end

    // ---------------- head evaluation ----------------
    logic                 purge_mode, expired, live, match, last_step;
    logic [TIME_BITS-1:0] age;
    logic signed [W-1:0]  g_dx, g_dy, n_dx, n_dy, n_fx;
    logic signed [W-1:0]  r_dx, r_dy;
    logic                 prev_inv, at_prev;
    logic                 c_pos, c_neg, c_zero;
    logic                 step, take, sub_op;
    logic [2:0]           hv;

    assign purge_mode = (mode_reg == MODE_LOOKUP) || (mode_reg == MODE_GREEDY) ||
                        (mode_reg == MODE_PERIM);
    assign age        = now_reg - h_stamp;
    assign expired    = purge_mode && h_valid && (now_reg >= h_stamp) &&
                        (LW'(age) >= LW'(life_reg));
    assign live       = h_valid && !expired;
    assign match      = live && (h_addr == addr_reg);
    assign last_step  = (cnt_reg == CNTW'(TABLE_ENTRIES - 1));

    assign g_dx = W'(h_x) - W'(px_reg);
    assign g_dy = W'(h_y) - W'(py_reg);
    assign n_dx = W'(h_x) - W'(sx_reg);
    assign n_dy = W'(h_y) - W'(sy_reg);
    // a neighbor sitting on this node points along +x
    assign n_fx = (n_dx == '0 && n_dy == '0) ? W'(1) : n_dx;
    assign r_dx = W'(vx_reg) - W'(sx_reg);
    assign r_dy = W'(vy_reg) - W'(sy_reg);

    assign prev_inv = (vx_reg == INV_C) && (vy_reg == INV_C);
    assign at_prev  = (h_x == vx_reg) && (h_y == vy_reg);

    assign c_neg  = comb_reg[CW-1];
    assign c_zero = (comb_reg == '0);
    assign c_pos  = !c_neg && !c_zero;

    // pair results: cross terms subtract, squares and dot terms add
    assign sub_op = (mode_reg == MODE_PERIM) && (k_reg == 3'd1 || k_reg == 3'd5);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        self_phase_next = self_phase_reg;
        written_next    = written_reg;
        have_best_next  = have_best_reg;
        bh_next         = bh_reg;
        q_found_next    = q_found_reg;
        done_next       = 1'b0;
        mode_next       = mode_reg;
        now_next        = now_reg;
        addr_next       = addr_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        pa_next         = pa_reg;
        comb_next       = comb_reg;
        self_d_next     = self_d_reg;
        best_d_next     = best_d_reg;
        best_addr_next  = best_addr_reg;
        q_x_next        = q_x_reg;
        q_y_next        = q_y_reg;
        q_stamp_next    = q_stamp_reg;
        o_addr_next     = o_addr_reg;
        o_found_next    = o_found_reg;
        o_x_next        = o_x_reg;
        o_y_next        = o_y_reg;
        o_stamp_next    = o_stamp_reg;
        o_status_next   = o_status_reg;
        step            = 1'b0;
        take            = 1'b0;
        hv              = bh_reg;
        wb_valid        = live;
        wb_addr         = h_addr;
        wb_x            = h_x;
        wb_y            = h_y;
        wb_stamp        = h_stamp;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next       = mode;
                    now_next        = TIME_BITS'(now);
                    addr_next       = node_addr;
                    px_next         = COORD_BITS'($unsigned(pos_x));
                    py_next         = COORD_BITS'($unsigned(pos_y));
                    sx_next         = COORD_BITS'($unsigned(self_x));
                    sy_next         = COORD_BITS'($unsigned(self_y));
                    vx_next         = COORD_BITS'($unsigned(prev_x));
                    vy_next         = COORD_BITS'($unsigned(prev_y));
                    cnt_next        = '0;
                    k_next          = 3'd0;
                    self_phase_next = 1'b0;
                    written_next    = 1'b0;
                    have_best_next  = 1'b0;
                    bh_next         = H_NONE;
                    q_found_next    = 1'b0;
                    state_next      = ST_PREP;
                end
            end
            ST_PREP:
            begin
                case (mode_reg)
                    MODE_GREEDY:
                    begin
                        // distance of this node to the destination first
                        cur_x_next      = W'(sx_reg) - W'(px_reg);
                        cur_y_next      = W'(sy_reg) - W'(py_reg);
                        k_next          = 3'd0;
                        self_phase_next = 1'b1;
                        state_next      = ST_START;
                    end
                    MODE_PERIM:
                    begin
                        rx_next    = (r_dx == '0 && r_dy == '0) ? W'(1) : r_dx;
                        ry_next    = r_dy;
                        state_next = ST_HEAD;
                    end
                    default:
                    begin
                        state_next = ST_HEAD;
                    end
                endcase
            end
            ST_HEAD:
            begin
                case (mode_reg)
                    MODE_ADD:
                    begin
                        // write into the first cell met that is free or holds a match;
                        // a match met after that write is dropped
                        if (!h_valid || h_addr == addr_reg)
                        begin
                            if (!written_reg)
                            begin
                                wb_valid     = 1'b1;
                                wb_addr      = addr_reg;
                                wb_x         = px_reg;
                                wb_y         = py_reg;
                                wb_stamp     = now_reg;
                                written_next = 1'b1;
                            end
                            else
                            begin
                                wb_valid = 1'b0;
                            end
                        end
                        step = 1'b1;
                    end
                    MODE_DEL:
                    begin
                        if (match)
                        begin
                            wb_valid = 1'b0;
                        end
                        step = 1'b1;
                    end
                    MODE_CLEAR:
                    begin
                        wb_valid = 1'b0;
                        step     = 1'b1;
                    end
                    MODE_QUERY, MODE_LOOKUP:
                    begin
                        if (match && (mode_reg == MODE_LOOKUP || addr_reg != 32'd0))
                        begin
                            q_found_next = 1'b1;
                            q_x_next     = h_x;
                            q_y_next     = h_y;
                            q_stamp_next = h_stamp;
                        end
                        step = 1'b1;
                    end
                    MODE_GREEDY:
                    begin
                        if (live)
                        begin
                            cur_x_next = g_dx;
                            cur_y_next = g_dy;
                            k_next     = 3'd0;
                            state_next = ST_START;
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end
                    MODE_PERIM:
                    begin
                        if (live && !prev_inv && !at_prev)
                        begin
                            cur_x_next = n_fx;
                            cur_y_next = n_dy;
                            k_next     = 3'd0;
                            state_next = ST_START;
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end
                    default:
                    begin
                        step = 1'b1;
                    end
                endcase
            end
            ST_START:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (!k_reg[0])
                    begin
                        pa_next    = mul_p;
                        k_next     = k_reg + 3'd1;
                        state_next = ST_START;
                    end
                    else
                    begin
                        comb_next  = sub_op ? (CW'(pa_reg) - CW'(mul_p))
                                            : (CW'(pa_reg) + CW'(mul_p));
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if (self_phase_reg)
                begin
                    self_d_next     = comb_reg;
                    self_phase_next = 1'b0;
                    state_next      = ST_HEAD;
                end
                else if (mode_reg == MODE_GREEDY)
                begin
                    take = !have_best_reg || (comb_reg < best_d_reg) ||
                           (comb_reg == best_d_reg && h_addr < best_addr_reg);
                    step = 1'b1;
                end
                else if (k_reg == 3'd1 && c_zero)
                begin
                    // collinear: the dot product splits back from same direction
                    k_next     = 3'd2;
                    state_next = ST_START;
                end
                else if (k_reg == 3'd5)
                begin
                    take = c_pos || (c_zero && h_addr < best_addr_reg);
                    step = 1'b1;
                end
                else
                begin
                    if (k_reg == 3'd1)
                    begin
                        hv = c_pos ? H_LEFT : H_RIGHT;
                    end
                    else
                    begin
                        hv = c_neg ? H_BACK : H_SAME;
                    end
                    if (hv < bh_reg)
                    begin
                        take = 1'b1;
                        step = 1'b1;
                    end
                    else if (hv > bh_reg)
                    begin
                        step = 1'b1;
                    end
                    else if (hv == H_LEFT || hv == H_RIGHT)
                    begin
                        k_next     = 3'd4;
                        state_next = ST_START;
                    end
                    else
                    begin
                        take = (h_addr < best_addr_reg);
                        step = 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                done_next     = 1'b1;
                o_addr_next   = 32'd0;
                o_found_next  = 1'b0;
                o_x_next      = INV_OUT;
                o_y_next      = INV_OUT;
                o_stamp_next  = 32'd0;
                o_status_next = STAT_OK;
                case (mode_reg)
                    MODE_ADD:
                    begin
                        if (!written_reg)
                        begin
                            o_status_next = STAT_FULL;
                        end
                    end
                    MODE_QUERY, MODE_LOOKUP:
                    begin
                        if (q_found_reg)
                        begin
                            o_addr_next  = addr_reg;
                            o_found_next = 1'b1;
                            o_x_next     = 32'(q_x_reg);
                            o_y_next     = 32'(q_y_reg);
                            o_stamp_next = 32'(q_stamp_reg);
                        end
                        else
                        begin
                            o_status_next = STAT_NONE;
                        end
                    end
                    MODE_GREEDY, MODE_PERIM:
                    begin
                        // greedy also needs the pick strictly nearer than this node
                        if (have_best_reg &&
                            (mode_reg == MODE_PERIM || self_d_reg > best_d_reg))
                        begin
                            o_addr_next  = best_addr_reg;
                            o_found_next = 1'b1;
                        end
                        else
                        begin
                            o_status_next = STAT_NONE;
                        end
                    end
                    default:
                    begin
                        o_status_next = STAT_OK;
                    end
                endcase
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (take)
        begin
            have_best_next = 1'b1;
            best_addr_next = h_addr;
            best_d_next    = comb_reg;
            bh_next        = hv;
            bx_next        = cur_x_reg;
            by_next        = cur_y_reg;
        end

        // advance the chain one cell
        if (step)
        begin
            cnt_next   = cnt_reg + 1'b1;
            state_next = last_step ? ST_FIN : ST_HEAD;
        end
    end

    assign shift = step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            k_reg          <= 3'd0;
            self_phase_reg <= 1'b0;
            written_reg    <= 1'b0;
            have_best_reg  <= 1'b0;
            bh_reg         <= H_NONE;
            q_found_reg    <= 1'b0;
            done_reg       <= 1'b0;
            mode_reg       <= MODE_ADD;
            life_reg       <= LIFETIME_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            k_reg          <= k_next;
            self_phase_reg <= self_phase_next;
            written_reg    <= written_next;
            have_best_reg  <= have_best_next;
            bh_reg         <= bh_next;
            q_found_reg    <= q_found_next;
            done_reg       <= done_next;
            mode_reg       <= mode_next;
            life_reg       <= life_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        addr_reg      <= addr_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        rx_reg        <= rx_next;
        ry_reg        <= ry_next;
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        pa_reg        <= pa_next;
        comb_reg      <= comb_next;
        self_d_reg    <= self_d_next;
        best_d_reg    <= best_d_next;
        best_addr_reg <= best_addr_next;
        q_x_reg       <= q_x_next;
        q_y_reg       <= q_y_next;
        q_stamp_reg   <= q_stamp_next;
        o_addr_reg    <= o_addr_next;
        o_found_reg   <= o_found_next;
        o_x_reg       <= o_x_next;
        o_y_reg       <= o_y_next;
        o_stamp_reg   <= o_stamp_next;
        o_status_reg  <= o_status_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign chosen_addr = o_addr_reg;
    assign found       = o_found_reg;
    assign found_x     = o_x_reg;
    assign found_y     = o_y_reg;
    assign found_stamp = o_stamp_reg;
    assign status      = o_status_reg;

endmodule

`default_nettype wire

FILE: rtl/core/gnt_checker.sv
// Port-level checker for geographic_neighbor_table, bound to the top level.
// Uses gnt_pkg.
`default_nettype none

module gnt_checker
    import gnt_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       start,
    input wire       busy,
    input wire       done,
    input wire       found,
    input wire [1:0] status
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("item finished without a result");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == STAT_OK))
        else $error("found result with error status");

endmodule

bind geographic_neighbor_table gnt_checker u_gnt_checker (.*);

`default_nettype wire

FILE: tb/tb_geographic_neighbor_table.sv
// Testbench for geographic_neighbor_table: directed table plus random items, checked
// against a behavioral predictor of the neighbor table. Depends on gnt_pkg and the RTL.
// Items go in by start/busy, the lifetime register is written over APB between phases.
`default_nettype none

module tb_geographic_neighbor_table;
    import gnt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT     = 16;
    localparam int WD_LIMIT = 20000;   // cycles with no item moving either way

    typedef logic signed [79:0] wide_s;

    typedef struct {
        logic [2:0]         md;
        logic [31:0]        tnow;
        logic [31:0]        addr;
        logic signed [31:0] px, py, sx, sy, vx, vy;
    } item_t;

    typedef struct {
        logic [31:0]        chosen;
        logic               fnd;
        logic signed [31:0] fx, fy;
        logic [31:0]        stamp;
        logic [1:0]         st;
    } res_t;

    typedef struct {
        item_t it;
        bit    chk;     // typed-in result instead of the predictor's
        res_t  want;
    } row_t;

    // DUT signals
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic [2:0] mode = '0;
    logic [31:0] now = '0, node_addr = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, self_x = '0, self_y = '0;
    logic signed [31:0] prev_x = '0, prev_y = '0;
    logic done;
    logic [31:0] chosen_addr;
    logic found;
    logic signed [31:0] found_x, found_y;
    logic [31:0] found_stamp;
    logic [1:0] status;

    geographic_neighbor_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .mode(mode), .now(now), .node_addr(node_addr),
        .pos_x(pos_x), .pos_y(pos_y), .self_x(self_x), .self_y(self_y),
        .prev_x(prev_x), .prev_y(prev_y),
        .done(done), .chosen_addr(chosen_addr), .found(found),
        .found_x(found_x), .found_y(found_y), .found_stamp(found_stamp), .status(status)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------------
    // Shadow neighbor table and lifetime register
    // ---------------------------------------------------------------------
    logic [31:0]        nb_valid;
    logic [31:0]        nb_addr  [NENT];
    logic signed [31:0] nb_x     [NENT];
    logic signed [31:0] nb_y     [NENT];
    logic [31:0]        nb_stamp [NENT];
    logic [31:0]        lifetime;

    res_t   pending_res[$];     // results still owed by the block
    item_t  cur_item;           // item currently offered on the input ports
    bit     cur_chk;
    res_t   cur_want;
    int     mismatches = 0;
    int     idle_cycles = 0;
    logic [31:0] t_now = '0;
    logic [31:0] addr_pool[24];

    function automatic res_t res_none(logic [1:0] st);
        res_t r;
        r.chosen = '0;
        r.fnd    = 1'b0;
        r.fx     = INV_OUT;
        r.fy     = INV_OUT;
        r.stamp  = '0;
        r.st     = st;
        return r;
    endfunction

    function automatic res_t res_hit(logic [31:0] a, logic signed [31:0] x,
                                     logic signed [31:0] y, logic [31:0] s);
        res_t r;
        r = res_none(STAT_OK);
        r.chosen = a;
        r.fnd    = 1'b1;
        r.fx     = x;
        r.fy     = y;
        r.stamp  = s;
        return r;
    endfunction

    function automatic int find_slot(logic [31:0] a);
        for (int i = 0; i < NENT; i++)
            if (nb_valid[i] && nb_addr[i] == a)
                return i;
        return -1;
    endfunction

    // drop entries whose stamp plus lifetime is at or below now; a stamp in the future stays
    function automatic void expire_stale(logic [31:0] t);
        for (int i = 0; i < NENT; i++)
            if (nb_valid[i] && t >= nb_stamp[i] && (t - nb_stamp[i]) >= lifetime)
                nb_valid[i] = 1'b0;
    endfunction

    function automatic int cross_sgn(longint ax, longint ay, longint bx, longint by);
        wide_s p;
        p = wide_s'(ax) * wide_s'(by) - wide_s'(ay) * wide_s'(bx);
        return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
    endfunction

    function automatic wide_s sq_dist(longint ax, longint ay, longint bx, longint by);
        wide_s dx, dy;
        dx = wide_s'(ax - bx);
        dy = wide_s'(ay - by);
        return dx * dx + dy * dy;
    endfunction

    // class of neighbor direction n against reference edge r (rank order of the package)
    function automatic int turn_class(longint rx, longint ry, longint nx, longint ny);
        wide_s dot;
        int c;
        c = cross_sgn(rx, ry, nx, ny);
        if (c > 0) return int'(H_LEFT);
        if (c < 0) return int'(H_RIGHT);
        dot = wide_s'(rx) * wide_s'(nx) + wide_s'(ry) * wide_s'(ny);
        return (dot < 0) ? int'(H_BACK) : int'(H_SAME);
    endfunction

    // Works out the result of one item and updates the shadow table.
    function automatic res_t route_predict(item_t it);
        res_t r;
        int k, best, bh, h, c;
        longint rx, ry, nx, ny, bx, by;
        wide_s bd, d;
        r = res_none(STAT_OK);
        best = -1;
        bd = '0;
        case (it.md)
            MODE_ADD: begin
                k = find_slot(it.addr);
                if (k < 0)
                    for (int i = NENT - 1; i >= 0; i--)
                        if (!nb_valid[i]) k = i;
                if (k < 0)
                    r.st = STAT_FULL;
                else begin
                    nb_valid[k] = 1'b1;
                    nb_addr[k]  = it.addr;
                    nb_x[k]     = it.px;
                    nb_y[k]     = it.py;
                    nb_stamp[k] = it.tnow;
                end
            end
            MODE_DEL: begin
                k = find_slot(it.addr);
                if (k >= 0) nb_valid[k] = 1'b0;
            end
            MODE_CLEAR: nb_valid = '0;
            MODE_QUERY, MODE_LOOKUP: begin
                if (it.md == MODE_LOOKUP) expire_stale(it.tnow);
                k = (it.md == MODE_QUERY && it.addr == 0) ? -1 : find_slot(it.addr);
                if (k < 0)
                    r.st = STAT_NONE;
                else
                    r = res_hit(it.addr, nb_x[k], nb_y[k], nb_stamp[k]);
            end
            MODE_GREEDY: begin
                expire_stale(it.tnow);
                for (int i = 0; i < NENT; i++) begin
                    if (!nb_valid[i]) continue;
                    d = sq_dist(nb_x[i], nb_y[i], it.px, it.py);
                    if (best < 0 || d < bd || (d == bd && nb_addr[i] < nb_addr[best])) begin
                        best = i;
                        bd = d;
                    end
                end
                // only a neighbor strictly nearer than this node counts
                if (best >= 0 && sq_dist(it.sx, it.sy, it.px, it.py) <= bd)
                    best = -1;
            end
            MODE_PERIM: begin
                expire_stale(it.tnow);
                rx = longint'(it.vx) - longint'(it.sx);
                ry = longint'(it.vy) - longint'(it.sy);
                if (rx == 0 && ry == 0) rx = 1;
                bh = int'(H_NONE);
                bx = 0;
                by = 0;
                if (!(it.vx == INV_OUT && it.vy == INV_OUT)) begin
                    for (int i = 0; i < NENT; i++) begin
                        if (!nb_valid[i]) continue;
                        if (nb_x[i] == it.vx && nb_y[i] == it.vy) continue;
                        nx = longint'(nb_x[i]) - longint'(it.sx);
                        ny = longint'(nb_y[i]) - longint'(it.sy);
                        if (nx == 0 && ny == 0) nx = 1;
                        h = turn_class(rx, ry, nx, ny);
                        if (h < bh) c = -1;
                        else if (h > bh) c = 1;
                        else if (h == int'(H_LEFT) || h == int'(H_RIGHT))
                            c = -cross_sgn(nx, ny, bx, by);
                        else c = 0;
                        if (c < 0 || (c == 0 && nb_addr[i] < nb_addr[best])) begin
                            best = i;
                            bh = h;
                            bx = nx;
                            by = ny;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (it.md == MODE_GREEDY || it.md == MODE_PERIM) begin
            if (best >= 0) begin
                r.chosen = nb_addr[best];
                r.fnd = 1'b1;
            end else
                r.st = STAT_NONE;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Monitor: results against the oldest expectation, then new items
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        res_t e;
        bit bad;
        bit moved;
        moved = 1'b0;
        if (rst_n) begin
            if (done) begin
                moved = 1'b1;
                if (pending_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with nothing expected: addr %h status %0d",
                                 chosen_addr, status);
                end else begin
                    e = pending_res.pop_front();
                    bad = (chosen_addr !== e.chosen) || (found !== e.fnd) ||
                          (found_x !== e.fx) || (found_y !== e.fy) ||
                          (found_stamp !== e.stamp) || (status !== e.st);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp addr %h f %b x %0d y %0d stamp %h st %0d",
                                      " | got addr %h f %b x %0d y %0d stamp %h st %0d"},
                                     e.chosen, e.fnd, e.fx, e.fy, e.stamp, e.st,
                                     chosen_addr, found, found_x, found_y, found_stamp,
                                     status);
                    end
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                e = route_predict(cur_item);
                if (cur_chk)
                    e = cur_want;
                pending_res = {pending_res, e};
            end
            if (moved)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Drivers (inputs change on the falling edge)
    // ---------------------------------------------------------------------
    task automatic send_item(item_t it, bit chk, res_t want, int idle_pct);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        cur_item  = it;
        cur_chk   = chk;
        cur_want  = want;
        mode      = it.md;
        now       = it.tnow;
        node_addr = it.addr;
        pos_x     = it.px;
        pos_y     = it.py;
        self_x    = it.sx;
        self_y    = it.sy;
        prev_x    = it.vx;
        prev_y    = it.vy;
        start     = 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_res.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one APB write then a read back of the lifetime register
    task automatic set_lifetime(logic [31:0] v);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; paddr = '0; pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        lifetime = v;
        pwrite = 1'b0; penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("lifetime read back: exp %h got %h", v, prdata);
        end
        @(negedge clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    function automatic item_t mk(logic [2:0] m, logic [31:0] t, logic [31:0] a,
                                 int x, int y, int sx, int sy, int vx, int vy);
        item_t it;
        it.md = m; it.tnow = t; it.addr = a;
        it.px = x; it.py = y; it.sx = sx; it.sy = sy; it.vx = vx; it.vy = vy;
        return it;
    endfunction

    function automatic logic signed [31:0] rnd_coord();
        if ($urandom_range(99) < 15)
            return $urandom;
        return $signed(32'($urandom_range(0, 4000))) - 2000;
    endfunction

    // random item: mostly pool addresses and nearby coordinates so picks hit real ties
    function automatic item_t rnd_item();
        item_t it;
        int w, j, n;
        int live[$];
        w = $urandom_range(99);
        if      (w < 30) it.md = MODE_ADD;
        else if (w < 38) it.md = MODE_DEL;
        else if (w < 40) it.md = MODE_CLEAR;
        else if (w < 50) it.md = MODE_QUERY;
        else if (w < 62) it.md = MODE_LOOKUP;
        else if (w < 80) it.md = MODE_GREEDY;
        else if (w < 98) it.md = MODE_PERIM;
        else             it.md = 3'd7;
        if ($urandom_range(99) < 3)
            t_now = $urandom;           // occasional jump, wraps time backwards too
        else
            t_now = t_now + $urandom_range(0, 600);
        it.tnow = t_now;
        it.addr = ($urandom_range(99) < 10) ? $urandom : addr_pool[$urandom_range(23)];
        it.px = rnd_coord();
        it.py = rnd_coord();
        it.sx = rnd_coord();
        it.sy = rnd_coord();
        it.vx = rnd_coord();
        it.vy = rnd_coord();
        for (int i = 0; i < NENT; i++)
            if (nb_valid[i]) live = {live, i};
        n = live.size();
        w = $urandom_range(99);
        if (n > 0 && w < 40) begin
            j = live[$urandom_range(n - 1)];
            it.vx = nb_x[j];
            it.vy = nb_y[j];
        end else if (w < 55) begin
            it.vx = INV_OUT;
            it.vy = INV_OUT;
        end else if (w < 65) begin
            it.vx = it.sx;
            it.vy = it.sy;
        end
        if (n > 0 && $urandom_range(99) < 10) begin
            j = live[$urandom_range(n - 1)];
            it.sx = nb_x[j];
            it.sy = nb_y[j];
        end
        return it;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        row_t tbl[$];
        row_t rw;
        res_t nil;
        logic [31:0] lt_set [4];
        int idle_set [4];
        int cnt_set [4];

        nb_valid = '0;
        lifetime = LIFETIME_RESET;
        cur_chk = 1'b0;
        foreach (addr_pool[i]) addr_pool[i] = $urandom;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        nil = res_none(STAT_OK);

        // directed rows: empty table, extremes, ties, perimeter corners, expiry
        rw.chk = 1; rw.want = res_none(STAT_NONE);
        rw.it = mk(MODE_QUERY, 0, 5, 0, 0, 0, 0, 0, 0);                       tbl = {tbl, rw};
        rw.it = mk(MODE_GREEDY, 0, 0, 100, 0, 0, 0, 0, 0);                    tbl = {tbl, rw};
        rw.it = mk(MODE_PERIM, 0, 0, 0, 0, 0, 0, 100, 0);                     tbl = {tbl, rw};
        rw.want = nil;
        rw.it = mk(MODE_ADD, 10, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);  tbl = {tbl, rw};
        rw.it = mk(MODE_ADD, 20, '1, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0); tbl = {tbl, rw};
        rw.want = res_none(STAT_NONE);
        rw.it = mk(MODE_QUERY, 20, 0, 0, 0, 0, 0, 0, 0);                      tbl = {tbl, rw};
        rw.want = res_hit('1, 32'h80000000, 32'h7fffffff, 20);
        rw.it = mk(MODE_QUERY, 25, '1, 0, 0, 0, 0, 0, 0);                     tbl = {tbl, rw};
        rw.want = res_hit(0, 32'h7fffffff, 32'h80000000, 10);
        rw.it = mk(MODE_LOOKUP, 30, 0, 0, 0, 0, 0, 0, 0);                     tbl = {tbl, rw};
        rw.want = nil;
        rw.it = mk(MODE_ADD, 40, 3, 0, 0, 0, 0, 0, 0);                        tbl = {tbl, rw};
        rw.it = mk(MODE_ADD, 40, 7, 512, 0, 0, 0, 0, 0);                      tbl = {tbl, rw};
        rw.it = mk(MODE_ADD, 40, 4, 512, 0, 0, 0, 0, 0);                      tbl = {tbl, rw};
        rw.it = mk(MODE_ADD, 40, 5, 0, 512, 0, 0, 0, 0);                      tbl = {tbl, rw};
        rw.it = mk(MODE_ADD, 40, 6, -512, 0, 0, 0, 0, 0);                     tbl = {tbl, rw};
        rw.chk = 0;
        rw.it = mk(MODE_GREEDY, 50, 0, 1024, 0, 0, 0, 0, 0);                  tbl = {tbl, rw};
        rw.chk = 1; rw.want = res_none(STAT_NONE);
        rw.it = mk(MODE_GREEDY, 50, 0, 0, 0, 0, 0, 0, 0);                     tbl = {tbl, rw};
        rw.it = mk(MODE_PERIM, 50, 0, 0, 0, 0, 0, -256, -256);                tbl = {tbl, rw};
        rw.chk = 0;
        rw.it = mk(MODE_PERIM, 60, 0, 0, 0, 0, 0, 512, 0);                    tbl = {tbl, rw};
        rw.it = mk(MODE_PERIM, 60, 0, 0, 0, 0, 0, 0, 0);                      tbl = {tbl, rw};
        rw.it = mk(MODE_PERIM, 60, 0, 0, 0, 0, 0, 1024, 0);                   tbl = {tbl, rw};
        rw.chk = 1; rw.want = nil;
        rw.it = mk(MODE_DEL, 70, 9, 0, 0, 0, 0, 0, 0);                        tbl = {tbl, rw};
        rw.it = mk(3'd7, 70, 9, 0, 0, 0, 0, 0, 0);                            tbl = {tbl, rw};
        rw.it = mk(MODE_ADD, 5000, 8, 33, -44, 0, 0, 0, 0);                   tbl = {tbl, rw};
        // stamp 40 plus 3000 is at or below 4000: gone
        rw.want = res_none(STAT_NONE);
        rw.it = mk(MODE_LOOKUP, 4000, 3, 0, 0, 0, 0, 0, 0);                   tbl = {tbl, rw};
        // time behind the stamp: never expired
        rw.want = res_hit(8, 33, -44, 5000);
        rw.it = mk(MODE_LOOKUP, 4500, 8, 0, 0, 0, 0, 0, 0);                   tbl = {tbl, rw};
        rw.want = nil;
        rw.it = mk(MODE_CLEAR, 4600, 0, 0, 0, 0, 0, 0, 0);                    tbl = {tbl, rw};
        rw.want = res_none(STAT_NONE);
        rw.it = mk(MODE_QUERY, 4600, 8, 0, 0, 0, 0, 0, 0);                    tbl = {tbl, rw};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (tbl[i])
            send_item(tbl[i].it, tbl[i].chk, tbl[i].want, 0);
        wait_drained();
        t_now = 5000;

        // random phases: lifetime setting, sender idle percentage, item count
        lt_set   = '{32'd1500, 32'hffffffff, 32'd0, LIFETIME_RESET};
        idle_set = '{0, 77, 0, 30};
        cnt_set  = '{300, 250, 100, 250};
        for (int p = 0; p < 4; p++) begin
            set_lifetime(lt_set[p]);
            for (int n = 0; n < cnt_set[p]; n++)
                send_item(rnd_item(), 0, nil, idle_set[p]);
            wait_drained();
        end

        repeat (50) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
